// ===== design/s3d_pkg.sv =====
// ----------------------------------------------------------------------------
// s3d_pkg: shared types and constants for the 3D six-point stencil
// Register indexes, default limits, tap bundle and dimension clamping.
// ----------------------------------------------------------------------------
package s3d_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int DEF_VOL_WIDTH  = 128;
    localparam int DEF_VOL_HEIGHT = 128;
    localparam int DEF_VOL_DEPTH  = 256;
    localparam int MAX_DEPTH      = 65535;

    localparam int VOXEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEPTH_W    = 16;

    localparam logic [1:0] CFG_SETTLE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOL_WIDTH  = 2'd0,
        CFG_VOL_HEIGHT = 2'd1,
        CFG_VOL_DEPTH  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [VOXEL_W-1:0] east;
        logic [VOXEL_W-1:0] west;
        logic [VOXEL_W-1:0] south;
        logic [VOXEL_W-1:0] north;
        logic [VOXEL_W-1:0] back;
    } t_taps;

    // zero acts as one, anything above the limit saturates
    function automatic logic [15:0] clamp_dim(input logic [15:0] v, input logic [15:0] maxv);
        logic [15:0] r;
        r = v;
        if (v == 16'd0) begin
            r = 16'd1;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

// ===== design/stencil_3d_six_neighbour_sum_core.sv =====
// ----------------------------------------------------------------------------
// stencil_3d_six_neighbour_sum_core: streaming 3D six-point stencil
// Takes voxels in raster order and emits, for each interior voxel, the sum
// of its six face neighbors modulo 256 with its coordinates.
//
//   port group   dir  handshake             words
//   in           in   i_in_valid/o_in_ready  i_voxel
//   out          out  o_out_valid/i_out_ready  neighbour_sum, pos_x/y/z, volume_done
//   cfg          in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// One voxel per cycle while o_in_ready is high; the result of the voxel that
// completes its neighborhood passes the ring memory read, then the sum register.
// o_in_ready stays low in a config write cycle and after it or after reset
// while plane size and ring offsets settle. The ring is not cleared.
// A stalled output holds one result in the output register and one in the
// sum stage; input stops only when both are full.
// ----------------------------------------------------------------------------
module stencil_3d_six_neighbour_sum_core #(
    parameter int MAX_WIDTH  = s3d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = s3d_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_voxel,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_neighbour_sum,
    output logic [7:0]                       o_pos_x,
    output logic [7:0]                       o_pos_y,
    output logic [15:0]                      o_pos_z,
    output logic                             o_volume_done,
    input  logic                             i_cfg_we,
    input  logic [s3d_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [s3d_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int XE    = WW + 1;
    localparam int YE    = HW + 1;
    localparam int DW    = s3d_pkg::DEPTH_W;
    localparam int ZE    = DW + 1;
    localparam int RST_W = (s3d_pkg::DEF_VOL_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : s3d_pkg::DEF_VOL_WIDTH;
    localparam int RST_H = (s3d_pkg::DEF_VOL_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : s3d_pkg::DEF_VOL_HEIGHT;

    logic [WW-1:0]    r_vol_w;
    logic [HW-1:0]    r_vol_h;
    logic [DW-1:0]    r_vol_d;
    logic [PW-1:0]    r_plane;
    logic [1:0]       r_settle;

    logic [XW-1:0]    r_col;
    logic [YW-1:0]    r_row;
    logic [DW-1:0]    r_pln;
    logic [XW-1:0]    n_col;
    logic [YW-1:0]    n_row;
    logic [DW-1:0]    n_pln;

    logic             r_s1_valid;
    logic [7:0]       r_s1_tap0;
    logic [7:0]       r_s1_x;
    logic [7:0]       r_s1_y;
    logic [15:0]      r_s1_z;
    logic             r_s1_done;

    logic             r_out_valid;
    logic [7:0]       r_out_sum;
    logic [7:0]       r_out_x;
    logic [7:0]       r_out_y;
    logic [15:0]      r_out_z;
    logic             r_out_done;

    logic [WW+HW-1:0] plane_full;
    logic [XE-1:0]    x_p1;
    logic [XE-1:0]    x_p2;
    logic [XE-1:0]    w_ext;
    logic [YE-1:0]    y_p1;
    logic [YE-1:0]    y_p2;
    logic [YE-1:0]    h_ext;
    logic [ZE-1:0]    z_p1;
    logic             res_hit;
    logic             res_done;
    logic             in_acc;
    logic             s1_adv;
    logic [7:0]       s1_sum;
    s3d_pkg::t_taps   taps;

    // config registers, held clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_w <= WW'(RST_W);
            r_vol_h <= HW'(RST_H);
            r_vol_d <= DW'(s3d_pkg::DEF_VOL_DEPTH);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                s3d_pkg::CFG_VOL_WIDTH: begin
                    r_vol_w <= WW'(s3d_pkg::clamp_dim({7'd0, i_cfg_data[8:0]},
                                                      16'(MAX_WIDTH)));
                end
                s3d_pkg::CFG_VOL_HEIGHT: begin
                    r_vol_h <= HW'(s3d_pkg::clamp_dim({7'd0, i_cfg_data[8:0]},
                                                      16'(MAX_HEIGHT)));
                end
                s3d_pkg::CFG_VOL_DEPTH: begin
                    r_vol_d <= s3d_pkg::clamp_dim(i_cfg_data[15:0],
                                                  16'(s3d_pkg::MAX_DEPTH));
                end
                default: begin
                end
            endcase
        end
    end

    assign plane_full = (WW+HW)'(r_vol_w) * (WW+HW)'(r_vol_h);

    always_ff @(posedge i_clk) begin
        r_plane <= plane_full[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= s3d_pkg::CFG_SETTLE;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_settle == 2'd0) && !i_cfg_we &&
                        (!r_s1_valid || !r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    assign x_p1  = XE'(r_col) + XE'(1);
    assign x_p2  = XE'(r_col) + XE'(2);
    assign w_ext = XE'(r_vol_w);
    assign y_p1  = YE'(r_row) + YE'(1);
    assign y_p2  = YE'(r_row) + YE'(2);
    assign h_ext = YE'(r_vol_h);
    assign z_p1  = ZE'(r_pln) + ZE'(1);

    // arriving voxel is the +z neighbor of the center one plane back
    assign res_hit  = (r_col != '0) && (x_p2 <= w_ext) &&
                      (r_row != '0) && (y_p2 <= h_ext) &&
                      (r_pln >= DW'(2)) && (r_pln < r_vol_d);
    assign res_done = (x_p2 == w_ext) && (y_p2 == h_ext) && (z_p1 == ZE'(r_vol_d));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_pln = r_pln;
        if (x_p1 >= w_ext) begin
            n_col = '0;
            if (y_p1 >= h_ext) begin
                n_row = '0;
                n_pln = (z_p1 >= ZE'(r_vol_d)) ? '0 : DW'(z_p1);
            end else begin
                n_row = YW'(y_p1);
            end
        end else begin
            n_col = XW'(x_p1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pln <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_pln <= n_pln;
        end
    end

    s3d_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_voxel  (i_voxel),
        .i_plane  (r_plane),
        .i_width  (r_vol_w),
        .o_taps   (taps)
    );

    // sum stage: ring read data lands here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc && res_hit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_hit) begin
            r_s1_tap0 <= i_voxel;
            r_s1_x    <= 8'(r_col);
            r_s1_y    <= 8'(r_row);
            r_s1_z    <= r_pln - DW'(1);
            r_s1_done <= res_done;
        end
    end

    assign s1_sum = r_s1_tap0 + taps.east + taps.west + taps.south + taps.north + taps.back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_sum  <= s1_sum;
            r_out_x    <= r_s1_x;
            r_out_y    <= r_s1_y;
            r_out_z    <= r_s1_z;
            r_out_done <= r_s1_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_neighbour_sum = r_out_sum;
    assign o_pos_x         = r_out_x;
    assign o_pos_y         = r_out_y;
    assign o_pos_z         = r_out_z;
    assign o_volume_done   = r_out_done;

    a_no_word_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_we) |-> !in_acc)
        else $error("word accepted while ring offsets settle");

    a_sum_stage_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_hit) |-> (!r_s1_valid || s1_adv))
        else $error("result accepted with sum stage full");

    a_sum_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_z) && $stable(r_s1_x)))
        else $error("sum stage lost a stalled result");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_hit) |=> r_s1_valid)
        else $error("interior voxel did not reach sum stage");

endmodule

// ===== design/s3d_window.sv =====
// ----------------------------------------------------------------------------
// s3d_window: voxel history ring for the six-point stencil
// Two synchronous ring memories over the last two planes plus one voxel.
// The wide ring keeps each voxel with its two predecessors, so one read
// yields both row neighbours; each ring serves two tap reads per word.
// ----------------------------------------------------------------------------
module s3d_window #(
    parameter int MAX_WIDTH  = s3d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = s3d_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_accept,
    input  logic [s3d_pkg::VOXEL_W-1:0]               i_voxel,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] i_plane,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]            i_width,
    output s3d_pkg::t_taps                            o_taps
);

    localparam int DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = AW + 1;
    localparam int VW    = s3d_pkg::VOXEL_W;

    logic [3*VW-1:0] mem_row [DEPTH];
    logic [VW-1:0]   mem_pix [DEPTH];

    logic [AW-1:0] r_wr;
    logic [VW-1:0] r_prev1;
    logic [VW-1:0] r_prev2;
    logic [AW-1:0] r_off_e;
    logic [AW-1:0] r_off_s;
    logic [AW-1:0] r_off_n;
    logic [AW-1:0] r_off_b;
    logic [2*VW-1:0] r_rd_ew;
    logic [VW-1:0]   r_rd_s;
    logic [VW-1:0]   r_rd_n;
    logic [VW-1:0]   r_rd_b;

    logic [OW-1:0] plane_e;
    logic [OW-1:0] width_e;
    logic [AW-1:0] addr_e;
    logic [AW-1:0] addr_s;
    logic [AW-1:0] addr_n;
    logic [AW-1:0] addr_b;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [OW-1:0] sum;
        sum = OW'(base) + OW'(off);
        if (sum >= OW'(DEPTH)) begin
            sum = sum - OW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign plane_e = OW'(i_plane);
    assign width_e = OW'(i_width);

    // ring offsets for delays plane-1, plane-width, plane+width, two planes
    always_ff @(posedge i_clk) begin
        r_off_e <= AW'(OW'(DEPTH) - plane_e + OW'(1));
        r_off_s <= AW'(OW'(DEPTH) - plane_e + width_e);
        r_off_n <= AW'(OW'(DEPTH) - plane_e - width_e);
        r_off_b <= AW'(OW'(DEPTH) - (plane_e << 1));
    end

    assign addr_e = ring_add(r_wr, r_off_e);
    assign addr_s = ring_add(r_wr, r_off_s);
    assign addr_n = ring_add(r_wr, r_off_n);
    assign addr_b = ring_add(r_wr, r_off_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
        end else if (i_accept) begin
            r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prev1 <= i_voxel;
            r_prev2 <= r_prev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            mem_row[r_wr] <= {i_voxel, r_prev1, r_prev2};
            r_rd_ew       <= {mem_row[addr_e][3*VW-1:2*VW], mem_row[addr_e][VW-1:0]};
            r_rd_s        <= mem_row[addr_s][3*VW-1:2*VW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            mem_pix[r_wr] <= i_voxel;
            r_rd_n        <= mem_pix[addr_n];
            r_rd_b        <= mem_pix[addr_b];
        end
    end

    assign o_taps.east  = r_rd_ew[2*VW-1:VW];
    assign o_taps.west  = r_rd_ew[VW-1:0];
    assign o_taps.south = r_rd_s;
    assign o_taps.north = r_rd_n;
    assign o_taps.back  = r_rd_b;

endmodule
